FILE: rtl/core/int16_checked_alu_macros.svh
// Assertion macros for the checked ALU top level.
// Depends on nothing; included by int16_checked_alu.sv.
`ifndef INT16_CHECKED_ALU_MACROS_SVH
`define INT16_CHECKED_ALU_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define ICA_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define ICA_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/ica_pkg.sv
// Shared types and codes of the checked ALU.
// Depends on nothing; used by ica_ctrl, ica_dp and int16_checked_alu.
package ica_pkg;

    typedef logic [3:0] op_t;
    typedef logic [2:0] st_t;

    localparam op_t OP_ADD    = 4'd0;
    localparam op_t OP_SUB    = 4'd1;
    localparam op_t OP_MUL    = 4'd2;
    localparam op_t OP_DIV    = 4'd3;
    localparam op_t OP_MOD    = 4'd4;
    localparam op_t OP_DIVMOD = 4'd5;
    localparam op_t OP_POW    = 4'd6;
    localparam op_t OP_NEG    = 4'd7;
    localparam op_t OP_ABS    = 4'd8;
    localparam op_t OP_INV    = 4'd9;
    localparam op_t OP_SHL    = 4'd10;
    localparam op_t OP_SHR    = 4'd11;
    localparam op_t OP_AND    = 4'd12;
    localparam op_t OP_XOR    = 4'd13;
    localparam op_t OP_OR     = 4'd14;
    localparam op_t OP_CMP    = 4'd15;

    localparam st_t ST_OK       = 3'd0;
    localparam st_t ST_OVF      = 3'd1;
    localparam st_t ST_DIV0     = 3'd2;
    localparam st_t ST_NEGSHIFT = 3'd3;
    localparam st_t ST_NEGEXP   = 3'd4;
    localparam st_t ST_ZEROMOD  = 3'd5;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_CAPTURE,
        CMD_EVAL,
        CMD_DIV_STEP,
        CMD_DIV_FIX,
        CMD_RED_FIX,
        CMD_MUL_ACC,
        CMD_MUL_SQ,
        CMD_MM_INIT_ACC,
        CMD_MM_INIT_SQ,
        CMD_MM_STEP,
        CMD_MM_ACC_DONE,
        CMD_MM_SQ_DONE,
        CMD_POW_FIX,
        CMD_EMIT
    } cmd_t;

    typedef enum logic [1:0] {
        PATH_SIMPLE,
        PATH_DIV,
        PATH_POW,
        PATH_POWMOD
    } path_t;

    typedef struct packed {
        path_t path;
        logic  cnt_last;
        logic  exp_zero;
        logic  exp_lsb;
    } dp_status_t;

endpackage

FILE: rtl/core/ica_dp.sv
// Datapath of the checked ALU: operand registers, shared multiplier,
// restoring divider, modular multiplier and result registers. Depends on ica_pkg.
module ica_dp #(
    parameter int DATA_WIDTH = 16
) (
    input  logic                         aclk,
    input  ica_pkg::cmd_t                cmd,
    input  ica_pkg::op_t                 req_type,
    input  logic signed [DATA_WIDTH-1:0] operand_a,
    input  logic signed [DATA_WIDTH-1:0] operand_b,
    input  logic signed [DATA_WIDTH-1:0] modulus,
    input  logic                         use_modulus,
    output ica_pkg::dp_status_t          dp_status,
    output logic signed [DATA_WIDTH-1:0] out_result,
    output logic signed [DATA_WIDTH-1:0] out_remainder,
    output ica_pkg::st_t                 out_status
);
    import ica_pkg::*;

    localparam int W  = DATA_WIDTH;
    localparam int CW = $clog2(DATA_WIDTH);
    localparam int PW = 2 * DATA_WIDTH + 4;

    op_t            op_reg;
    logic [W-1:0]   a_reg, b_reg, m_reg;
    logic           usem_reg;

    logic [W-1:0]   res_reg, rem_reg;
    st_t            st_reg;
    logic [W-1:0]   out_res_reg, out_rem_reg;
    st_t            out_st_reg;

    logic [W-1:0]   part_reg, quo_reg, dvs_reg;
    logic [CW-1:0]  cnt_reg;
    logic [W:0]     acc_reg, base_reg;
    logic [W-2:0]   exp_reg;
    logic [W-1:0]   mmx_reg, mmy_reg, mmr_reg;

    // operand properties
    logic           a_neg, b_neg, m_neg, a_zero, b_zero, m_zero, a_min, b_m1;
    logic [W-1:0]   a_mag, b_mag, m_mag;
    path_t          path;

    assign a_neg  = a_reg[W-1];
    assign b_neg  = b_reg[W-1];
    assign m_neg  = m_reg[W-1];
    assign a_zero = (a_reg == '0);
    assign b_zero = (b_reg == '0);
    assign m_zero = (m_reg == '0);
    assign a_min  = a_neg && (a_reg[W-2:0] == '0);
    assign b_m1   = &b_reg;
    assign a_mag  = a_neg ? (~a_reg + 1'b1) : a_reg;
    assign b_mag  = b_neg ? (~b_reg + 1'b1) : b_reg;
    assign m_mag  = m_neg ? (~m_reg + 1'b1) : m_reg;

    always_comb begin
        path = PATH_SIMPLE;
        if ((op_reg == OP_DIV) || (op_reg == OP_MOD) || (op_reg == OP_DIVMOD)) begin
            if (!b_zero && !(a_min && b_m1)) path = PATH_DIV;
        end else if (op_reg == OP_POW) begin
            if (!b_neg && !(usem_reg && m_zero)) path = usem_reg ? PATH_POWMOD : PATH_POW;
        end
    end

    // shared multiplier
    logic signed [W+1:0] mul_x, mul_y;
    logic signed [PW-1:0] mul_p;
    logic                mul_fits;
    logic [W:0]          mul_sat;

    always_comb begin
        unique case (cmd)
            CMD_MUL_ACC: begin
                mul_x = $signed({1'b0, acc_reg});
                mul_y = $signed({1'b0, base_reg});
            end
            CMD_MUL_SQ: begin
                mul_x = $signed({1'b0, base_reg});
                mul_y = $signed({1'b0, base_reg});
            end
            default: begin
                mul_x = $signed({{2{a_reg[W-1]}}, a_reg});
                mul_y = $signed({{2{b_reg[W-1]}}, b_reg});
            end
        endcase
    end

    assign mul_p    = mul_x * mul_y;
    assign mul_fits = (&mul_p[PW-1:W-1]) || !(|mul_p[PW-1:W-1]);
    // clamp at 2**W: anything above stands for "too large"
    assign mul_sat  = ((mul_p[PW-1:W+1] != '0) || (mul_p[W] && (mul_p[W-1:0] != '0)))
                      ? {1'b1, {W{1'b0}}} : mul_p[W:0];

    // directly evaluated operations and error codes
    logic [W:0]   sum_w, diff_w;
    logic         shamt_big;
    logic [CW-1:0] shamt;
    logic [W-1:0] ev_res;
    st_t          ev_st;

    assign sum_w     = {a_reg[W-1], a_reg} + {b_reg[W-1], b_reg};
    assign diff_w    = {a_reg[W-1], a_reg} - {b_reg[W-1], b_reg};
    assign shamt_big = (b_reg >= W'(DATA_WIDTH));
    assign shamt     = b_reg[CW-1:0];

    always_comb begin
        ev_res = '0;
        ev_st  = ST_OK;
        unique case (op_reg)
            OP_ADD: begin
                ev_res = sum_w[W-1:0];
                if (sum_w[W] != sum_w[W-1]) ev_st = ST_OVF;
            end
            OP_SUB: begin
                ev_res = diff_w[W-1:0];
                if (diff_w[W] != diff_w[W-1]) ev_st = ST_OVF;
            end
            OP_MUL: begin
                ev_res = mul_p[W-1:0];
                if (!mul_fits) ev_st = ST_OVF;
            end
            OP_DIV, OP_MOD, OP_DIVMOD: ev_st = b_zero ? ST_DIV0 : ST_OVF;
            OP_POW: begin
                if (b_neg) ev_st = a_zero ? ST_DIV0 : ST_NEGEXP;
                else       ev_st = ST_ZEROMOD;
            end
            OP_NEG: begin
                ev_res = ~a_reg + 1'b1;
                if (a_min) ev_st = ST_OVF;
            end
            OP_ABS: begin
                ev_res = a_mag;
                if (a_min) ev_st = ST_OVF;
            end
            OP_INV: ev_res = ~a_reg;
            OP_SHL: begin
                if (b_neg)          ev_st  = ST_NEGSHIFT;
                else if (shamt_big) ev_res = '0;
                else                ev_res = a_reg << shamt;
            end
            OP_SHR: begin
                if (b_neg)          ev_st  = ST_NEGSHIFT;
                else if (shamt_big) ev_res = {W{a_neg}};
                else                ev_res = W'($signed(a_reg) >>> shamt);
            end
            OP_AND: ev_res = a_reg & b_reg;
            OP_XOR: ev_res = a_reg ^ b_reg;
            OP_OR:  ev_res = a_reg | b_reg;
            default: begin
                if ($signed(a_reg) < $signed(b_reg))      ev_res = '1;
                else if ($signed(a_reg) > $signed(b_reg)) ev_res = W'(1);
                else                                      ev_res = '0;
            end
        endcase
        if (ev_st != ST_OK) ev_res = '0;
    end

    // restoring divider step
    logic [W:0]   dv_sh, dv_diff;
    logic         dv_ge;

    assign dv_sh   = {part_reg, quo_reg[W-1]};
    assign dv_ge   = (dv_sh >= {1'b0, dvs_reg});
    assign dv_diff = dv_sh - {1'b0, dvs_reg};

    // floor correction of the magnitude quotient and remainder
    logic         sgn_diff, r_nz;
    logic [W:0]   q_mag;
    logic [W-1:0] q_fix, r_mag, r_fix;

    assign sgn_diff = a_neg ^ b_neg;
    assign r_nz     = (part_reg != '0);
    assign q_mag    = {1'b0, quo_reg} + (W+1)'(sgn_diff && r_nz);
    assign q_fix    = sgn_diff ? (~q_mag[W-1:0] + 1'b1) : q_mag[W-1:0];
    assign r_mag    = (sgn_diff && r_nz) ? (b_mag - part_reg) : part_reg;
    assign r_fix    = b_neg ? (~r_mag + 1'b1) : r_mag;

    // interleaved modular multiply step
    logic [W:0]   mm_t, mm_t1, mm_t2, mm_m;

    assign mm_m  = {1'b0, m_mag};
    assign mm_t  = {mmr_reg, 1'b0} + (mmy_reg[W-1] ? {1'b0, mmx_reg} : '0);
    assign mm_t1 = (mm_t >= mm_m) ? (mm_t - mm_m) : mm_t;
    assign mm_t2 = (mm_t1 >= mm_m) ? (mm_t1 - mm_m) : mm_t1;

    // final power result
    logic         pw_neg, pw_ovf;
    logic [W:0]   pw_lim;
    logic [W-1:0] pw_res;

    assign pw_neg = a_neg && b_reg[0];
    assign pw_lim = pw_neg ? {2'b01, {(W-1){1'b0}}} : {2'b00, {(W-1){1'b1}}};
    always_comb begin
        pw_ovf = 1'b0;
        if (usem_reg) begin
            pw_res = (m_neg && (acc_reg != '0)) ? (acc_reg[W-1:0] - m_mag) : acc_reg[W-1:0];
        end else begin
            pw_ovf = (acc_reg > pw_lim);
            pw_res = pw_ovf ? '0 : (pw_neg ? (~acc_reg[W-1:0] + 1'b1) : acc_reg[W-1:0]);
        end
    end

    always_ff @(posedge aclk) begin
        unique case (cmd)
            CMD_CAPTURE: begin
                op_reg   <= req_type;
                a_reg    <= operand_a;
                b_reg    <= operand_b;
                m_reg    <= modulus;
                usem_reg <= use_modulus;
            end
            CMD_EVAL: begin
                res_reg  <= ev_res;
                rem_reg  <= '0;
                st_reg   <= (path == PATH_SIMPLE) ? ev_st : ST_OK;
                part_reg <= '0;
                quo_reg  <= a_mag;
                dvs_reg  <= (path == PATH_POWMOD) ? m_mag : b_mag;
                cnt_reg  <= CW'(DATA_WIDTH - 1);
                acc_reg  <= (W+1)'(1);
                base_reg <= {1'b0, a_mag};
                exp_reg  <= b_reg[W-2:0];
            end
            CMD_DIV_STEP: begin
                part_reg <= dv_ge ? dv_diff[W-1:0] : dv_sh[W-1:0];
                quo_reg  <= {quo_reg[W-2:0], dv_ge};
                cnt_reg  <= cnt_reg - 1'b1;
            end
            CMD_DIV_FIX: begin
                res_reg <= (op_reg == OP_MOD) ? r_fix : q_fix;
                rem_reg <= (op_reg == OP_DIVMOD) ? r_fix : '0;
            end
            CMD_RED_FIX: begin
                base_reg <= {1'b0, (a_neg && r_nz) ? (m_mag - part_reg) : part_reg};
                acc_reg  <= (m_mag == W'(1)) ? '0 : (W+1)'(1);
            end
            CMD_MUL_ACC: acc_reg <= mul_sat;
            CMD_MUL_SQ: begin
                base_reg <= mul_sat;
                exp_reg  <= exp_reg >> 1;
            end
            CMD_MM_INIT_ACC: begin
                mmx_reg <= acc_reg[W-1:0];
                mmy_reg <= base_reg[W-1:0];
                mmr_reg <= '0;
                cnt_reg <= CW'(DATA_WIDTH - 1);
            end
            CMD_MM_INIT_SQ: begin
                mmx_reg <= base_reg[W-1:0];
                mmy_reg <= base_reg[W-1:0];
                mmr_reg <= '0;
                cnt_reg <= CW'(DATA_WIDTH - 1);
            end
            CMD_MM_STEP: begin
                mmr_reg <= mm_t2[W-1:0];
                mmy_reg <= mmy_reg << 1;
                cnt_reg <= cnt_reg - 1'b1;
            end
            CMD_MM_ACC_DONE: acc_reg <= {1'b0, mmr_reg};
            CMD_MM_SQ_DONE: begin
                base_reg <= {1'b0, mmr_reg};
                exp_reg  <= exp_reg >> 1;
            end
            CMD_POW_FIX: begin
                res_reg <= pw_res;
                st_reg  <= pw_ovf ? ST_OVF : ST_OK;
            end
            CMD_EMIT: begin
                out_res_reg <= res_reg;
                out_rem_reg <= rem_reg;
                out_st_reg  <= st_reg;
            end
            default: ;
        endcase
    end

    assign dp_status.path     = path;
    assign dp_status.cnt_last = (cnt_reg == '0);
    assign dp_status.exp_zero = (exp_reg == '0);
    assign dp_status.exp_lsb  = exp_reg[0];

    assign out_result    = out_res_reg;
    assign out_remainder = out_rem_reg;
    assign out_status    = out_st_reg;

endmodule

FILE: rtl/core/ica_ctrl.sv
// Controller of the checked ALU: sequences the datapath and runs both handshakes.
// Depends on ica_pkg.
module ica_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    output logic                m_valid,
    input  logic                m_ready,
    input  ica_pkg::dp_status_t dp_status,
    output ica_pkg::cmd_t       cmd
);
    import ica_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EVAL,
        S_DIV_STEP,
        S_DIV_FIX,
        S_RED_STEP,
        S_RED_FIX,
        S_POW_TEST,
        S_MUL_ACC,
        S_MUL_SQ,
        S_MMA_INIT,
        S_MMA_STEP,
        S_MMA_DONE,
        S_MMS_INIT,
        S_MMS_STEP,
        S_MMS_DONE,
        S_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd          = CMD_NONE;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd        = CMD_CAPTURE;
                    state_next = S_EVAL;
                end
            end
            S_EVAL: begin
                cmd = CMD_EVAL;
                unique case (dp_status.path)
                    PATH_DIV:    state_next = S_DIV_STEP;
                    PATH_POW:    state_next = S_POW_TEST;
                    PATH_POWMOD: state_next = S_RED_STEP;
                    default:     state_next = S_FINISH;
                endcase
            end
            S_DIV_STEP: begin
                cmd = CMD_DIV_STEP;
                if (dp_status.cnt_last) state_next = S_DIV_FIX;
            end
            S_DIV_FIX: begin
                cmd        = CMD_DIV_FIX;
                state_next = S_FINISH;
            end
            S_RED_STEP: begin
                cmd = CMD_DIV_STEP;
                if (dp_status.cnt_last) state_next = S_RED_FIX;
            end
            S_RED_FIX: begin
                cmd        = CMD_RED_FIX;
                state_next = S_POW_TEST;
            end
            S_POW_TEST: begin
                priority if (dp_status.exp_zero) begin
                    cmd        = CMD_POW_FIX;
                    state_next = S_FINISH;
                end else if (dp_status.path == PATH_POWMOD) begin
                    state_next = dp_status.exp_lsb ? S_MMA_INIT : S_MMS_INIT;
                end else begin
                    state_next = dp_status.exp_lsb ? S_MUL_ACC : S_MUL_SQ;
                end
            end
            S_MUL_ACC: begin
                cmd        = CMD_MUL_ACC;
                state_next = S_MUL_SQ;
            end
            S_MUL_SQ: begin
                cmd        = CMD_MUL_SQ;
                state_next = S_POW_TEST;
            end
            S_MMA_INIT: begin
                cmd        = CMD_MM_INIT_ACC;
                state_next = S_MMA_STEP;
            end
            S_MMA_STEP: begin
                cmd = CMD_MM_STEP;
                if (dp_status.cnt_last) state_next = S_MMA_DONE;
            end
            S_MMA_DONE: begin
                cmd        = CMD_MM_ACC_DONE;
                state_next = S_MMS_INIT;
            end
            S_MMS_INIT: begin
                cmd        = CMD_MM_INIT_SQ;
                state_next = S_MMS_STEP;
            end
            S_MMS_STEP: begin
                cmd = CMD_MM_STEP;
                if (dp_status.cnt_last) state_next = S_MMS_DONE;
            end
            S_MMS_DONE: begin
                cmd        = CMD_MM_SQ_DONE;
                state_next = S_POW_TEST;
            end
            default: begin
                if (out_free) begin
                    cmd          = CMD_EMIT;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;

endmodule

FILE: rtl/core/int16_checked_alu.sv
// Checked signed ALU, one item at a time; result register parts the two sides.
// Simple ops finish after evaluation; div/mod/divmod run a restoring divider (one quotient
// bit per cycle), pow squares and multiplies, and modular pow reduces the base and runs
// an interleaved modular multiply per step. A new item is accepted only after the last
// result has gone to the output register, which waits while m_valid is held unread.
// Reset (aresetn low, synchronous) idles the controller and drops m_valid.
`include "int16_checked_alu_macros.svh"

module int16_checked_alu #(
    parameter int DATA_WIDTH = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // input channel
    input  logic                         s_valid,
    output logic                         s_ready,
    input  ica_pkg::op_t                 s_req_type,
    input  logic signed [DATA_WIDTH-1:0] s_operand_a,
    input  logic signed [DATA_WIDTH-1:0] s_operand_b,
    input  logic signed [DATA_WIDTH-1:0] s_modulus,
    input  logic                         s_use_modulus,
    // result channel
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic signed [DATA_WIDTH-1:0] m_result,
    output logic signed [DATA_WIDTH-1:0] m_remainder,
    output ica_pkg::st_t                 m_status
);
    import ica_pkg::*;

    // command and status between controller and datapath
    cmd_t       cmd;
    dp_status_t dp_status;

    // The controller walks one item through capture, evaluation and any
    // iterative phase, then hands the result to the output register as soon
    // as that register is free or being drained.
    ica_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .dp_status (dp_status),
        .cmd       (cmd)
    );

    // The datapath holds operands, the divider, the multiplier, the modular
    // multiplier and the output register; it advances only on commands.
    ica_dp #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .aclk          (aclk),
        .cmd           (cmd),
        .req_type      (s_req_type),
        .operand_a     (s_operand_a),
        .operand_b     (s_operand_b),
        .modulus       (s_modulus),
        .use_modulus   (s_use_modulus),
        .dp_status     (dp_status),
        .out_result    (m_result),
        .out_remainder (m_remainder),
        .out_status    (m_status)
    );

    // An error result carries zero in both value fields.
    `ICA_ASSERT_SAME(a_err_zero, aclk, aresetn, m_valid && (m_status != ST_OK), (m_result == '0) && (m_remainder == '0), "error result with nonzero payload")
    // Status codes stay within the defined set.
    `ICA_ASSERT_SAME(a_st_range, aclk, aresetn, m_valid, m_status <= ST_ZEROMOD, "undefined status code")
    // Only one item is in flight: an accept closes the input side.
    `ICA_ASSERT_NEXT(a_one_item, aclk, aresetn, s_valid && s_ready, !s_ready, "second item taken while busy")

endmodule
